/* hdl/espc_pkg.sv */
// ----------------------------------------------------------------------------
// espc_pkg
// Types, constants and the control store of the encoder speed P controller.
// ----------------------------------------------------------------------------
package espc_pkg;

    localparam int PC_W     = 4;
    localparam int PROD_W   = 58;
    localparam int LEVEL_W  = 24;
    localparam int MAG_W    = 23;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 24;

    // 100 percent in Q7.16
    localparam logic [MAG_W-1:0] FULL_DUTY = 23'd6553600;
    // ceil(2^30 / 100); exact floor division for dividends below 2^23
    localparam logic [23:0]      RECIP_100 = 24'd10737419;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_RPM_SCALE      = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_GAIN           = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_STOP_SPEED     = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_STOP_DUTY      = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_MAX_SPEED      = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_REVERSE_WIRING = 3'd5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_DELTA,
        OP_MUL_SPEED,
        OP_SPEED,
        OP_MUL_GAIN,
        OP_ACCUM,
        OP_LEVEL,
        OP_MUL_CMP,
        OP_MUL_RECIP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,   // advance
        C_IN,     // go to target once an input transfer completes, else hold
        C_OUT,    // go to target once the output register is free, else hold
        C_FAULT,  // go to target when the fault is latched, else advance
        C_JUMP    // go to target
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:    w = '{op: OP_TAKE,      cond: C_IN,    target: 4'd1};
            4'd1:    w = '{op: OP_DELTA,     cond: C_FAULT, target: 4'd7};
            4'd2:    w = '{op: OP_MUL_SPEED, cond: C_NEXT,  target: 4'd0};
            4'd3:    w = '{op: OP_SPEED,     cond: C_NEXT,  target: 4'd0};
            4'd4:    w = '{op: OP_MUL_GAIN,  cond: C_NEXT,  target: 4'd0};
            4'd5:    w = '{op: OP_ACCUM,     cond: C_NEXT,  target: 4'd0};
            4'd6:    w = '{op: OP_LEVEL,     cond: C_NEXT,  target: 4'd0};
            4'd7:    w = '{op: OP_MUL_CMP,   cond: C_NEXT,  target: 4'd0};
            4'd8:    w = '{op: OP_MUL_RECIP, cond: C_NEXT,  target: 4'd0};
            4'd9:    w = '{op: OP_EMIT,      cond: C_OUT,   target: 4'd0};
            default: w = '{op: OP_NOP,       cond: C_JUMP,  target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

/* hdl/encoder_speed_p_controller.sv */
// ----------------------------------------------------------------------------
// encoder_speed_p_controller
// Encoder speed measurement and incremental proportional drive for one motor.
// ----------------------------------------------------------------------------
// Each item runs the microprogram from the input transfer to m_tvalid (steps
// 2 to 6 skipped once the fault is latched); the emit step holds while the
// output register is full and m_tready is low. A 10-step microprogram drives
// one shared 33x25 multiplier, and one item is in work at a time.
// Reset (aresetn low, synchronous): sequencer to step 0, output empty,
// history, level, overspeed run and fault cleared, registers to defaults.
module encoder_speed_p_controller #(
    parameter int PWM_PERIOD = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [espc_pkg::CFG_A_W-1:0]     cfg_index,
    input  logic [espc_pkg::CFG_D_W-1:0]     cfg_wdata,
    // input: position_count[15:0], wrap_count[31:16], target_speed[47:32]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,
    // result: measured_speed[15:0], drive_level[39:16], compare_value[55:40],
    // pin_one[56], pin_two[57], fault[58], zero[63:59]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata
);
    import espc_pkg::*;

    localparam logic [15:0] PERIOD = 16'(PWM_PERIOD);

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uw;

    // configuration
    logic [23:0] rpm_scale_reg;
    logic [19:0] gain_reg;
    logic [14:0] stop_speed_reg;
    logic [6:0]  stop_duty_reg;
    logic [14:0] max_speed_reg;
    logic        reverse_reg;

    // channel state
    logic [15:0]                last_pos_reg, last_pos_next;
    logic [15:0]                last_wraps_reg, last_wraps_next;
    logic signed [LEVEL_W-1:0]  level_reg, level_next;
    logic [2:0]                 run_reg, run_next;
    logic                       fault_reg, fault_next;

    // working registers
    logic [15:0]                pos_reg, pos_next;
    logic [15:0]                wraps_reg, wraps_next;
    logic signed [15:0]         target_reg, target_next;
    logic [31:0]                delta_reg, delta_next;
    logic signed [15:0]         speed_reg, speed_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;

    // datapath signals
    logic signed [32:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [16:0]       err;
    logic signed [41:0]       quo;
    logic [16:0]              spd_mag;
    logic [MAG_W-1:0]         lvl_mag;
    logic [MAG_W-1:0]         duty_left;
    logic signed [39:0]       lv, lv_clamp, lim;
    logic                     in_xfer, out_free, fwd, bwd;

    assign uw       = ucode(pc_reg);
    assign s_tready = (uw.op == OP_TAKE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign err     = 17'(target_reg) - 17'(speed_reg);
    assign spd_mag = speed_reg[15] ? 17'(-17'(speed_reg)) : {1'b0, speed_reg};
    assign lvl_mag = level_reg[LEVEL_W-1] ? MAG_W'(-level_reg) : level_reg[MAG_W-1:0];
    assign duty_left = FULL_DUTY - lvl_mag;
    assign quo = prod_reg[PROD_W-1:16]
               + 42'(prod_reg[PROD_W-1] && (prod_reg[15:0] != 16'd0));
    assign lim = $signed({17'd0, stop_duty_reg, 16'd0});
    assign lv  = prod_reg[39:0];

    always_comb begin
        case (uw.op)
            OP_MUL_SPEED: begin
                mul_a = {delta_reg[31], delta_reg};
                mul_b = {1'b0, rpm_scale_reg};
            end
            OP_MUL_GAIN: begin
                mul_a = 33'(err);
                mul_b = {5'd0, gain_reg};
            end
            OP_MUL_CMP: begin
                mul_a = {17'd0, PERIOD};
                mul_b = {2'd0, duty_left};
            end
            OP_MUL_RECIP: begin
                mul_a = {10'd0, prod_reg[38:16]};
                mul_b = {1'b0, RECIP_100};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // clamp to full duty, then the stop limit at low speed; zero when the gain is zero
    always_comb begin
        lv_clamp = lv;
        if (lv > $signed(40'(FULL_DUTY))) begin
            lv_clamp = $signed(40'(FULL_DUTY));
        end else if (lv < -$signed(40'(FULL_DUTY))) begin
            lv_clamp = -$signed(40'(FULL_DUTY));
        end
        if (spd_mag < {2'd0, stop_speed_reg}) begin
            if (lv_clamp > lim) begin
                lv_clamp = lim;
            end else if (lv_clamp < -lim) begin
                lv_clamp = -lim;
            end
        end
        if (gain_reg == 20'd0) begin
            lv_clamp = '0;
        end
    end

    assign fwd = !fault_reg && !level_reg[LEVEL_W-1] && (level_reg != '0);
    assign bwd = !fault_reg && level_reg[LEVEL_W-1];

    always_comb begin
        pos_next        = pos_reg;
        wraps_next      = wraps_reg;
        target_next     = target_reg;
        delta_next      = delta_reg;
        speed_next      = speed_reg;
        prod_next       = prod_reg;
        last_pos_next   = last_pos_reg;
        last_wraps_next = last_wraps_reg;
        level_next      = level_reg;
        run_next        = run_reg;
        fault_next      = fault_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (uw.op)
            OP_TAKE: begin
                if (in_xfer) begin
                    pos_next    = s_tdata[15:0];
                    wraps_next  = s_tdata[31:16];
                    target_next = s_tdata[47:32];
                end
            end
            OP_DELTA: begin
                delta_next = {wraps_reg, pos_reg} - {last_wraps_reg, last_pos_reg};
                speed_next = '0;
            end
            OP_MUL_SPEED, OP_MUL_GAIN, OP_MUL_CMP, OP_MUL_RECIP: begin
                prod_next = mul_p;
            end
            OP_SPEED: begin
                if (quo > 42'sd32767) begin
                    speed_next = 16'sh7FFF;
                end else if (quo < -42'sd32768) begin
                    speed_next = 16'sh8000;
                end else begin
                    speed_next = quo[15:0];
                end
            end
            OP_ACCUM: begin
                prod_next = prod_reg + PROD_W'(level_reg);
            end
            OP_LEVEL: begin
                level_next      = lv_clamp[LEVEL_W-1:0];
                last_pos_next   = pos_reg;
                last_wraps_next = wraps_reg;
                if (spd_mag > {2'd0, max_speed_reg} && gain_reg != 20'd0) begin
                    run_next = run_reg[2] ? run_reg : run_reg + 3'd1;
                end else begin
                    run_next = '0;
                end
                fault_next = fault_reg || run_next[2];
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, fault_reg,
                                     reverse_reg ? fwd : bwd,
                                     reverse_reg ? bwd : fwd,
                                     prod_reg[45:30], level_reg, speed_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (uw.cond)
            C_NEXT:  pc_next = pc_reg + 4'd1;
            C_IN:    pc_next = in_xfer ? uw.target : pc_reg;
            C_OUT:   pc_next = out_free ? uw.target : pc_reg;
            C_FAULT: pc_next = fault_reg ? uw.target : pc_reg + 4'd1;
            C_JUMP:  pc_next = uw.target;
            default: pc_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            last_pos_reg   <= '0;
            last_wraps_reg <= '0;
            level_reg      <= '0;
            run_reg        <= '0;
            fault_reg      <= 1'b0;
            rpm_scale_reg  <= '0;
            gain_reg       <= '0;
            stop_speed_reg <= '0;
            stop_duty_reg  <= 7'd100;
            max_speed_reg  <= 15'd32767;
            reverse_reg    <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            m_tvalid_reg   <= m_tvalid_next;
            last_pos_reg   <= last_pos_next;
            last_wraps_reg <= last_wraps_next;
            level_reg      <= level_next;
            run_reg        <= run_next;
            fault_reg      <= fault_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RPM_SCALE:      rpm_scale_reg  <= cfg_wdata;
                    REG_GAIN:           gain_reg       <= cfg_wdata[19:0];
                    REG_STOP_SPEED:     stop_speed_reg <= cfg_wdata[14:0];
                    REG_STOP_DUTY:      stop_duty_reg  <= cfg_wdata[6:0];
                    REG_MAX_SPEED:      max_speed_reg  <= cfg_wdata[14:0];
                    REG_REVERSE_WIRING: reverse_reg    <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        wraps_reg   <= wraps_next;
        target_reg  <= target_next;
        delta_reg   <= delta_next;
        speed_reg   <= speed_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
